// ----- hdl/pid_integral_separation_macros.svh -----
// assertion macros shared by the controller files
`ifndef PID_INTEGRAL_SEPARATION_MACROS_SVH
`define PID_INTEGRAL_SEPARATION_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every clock edge outside reset
`define PIS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define PIS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PIS_ASSERT(label, clk, rst_n, prop, msg)
`define PIS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- hdl/pid_is_pkg.sv -----
package pid_is_pkg;

    // field widths
    localparam int DATA_W      = 32;
    localparam int BAND_W      = 31;
    localparam int ERR_W       = 33;
    localparam int DIFF_W      = 34;
    localparam int ISUM_W      = 34;
    localparam int FRAC_W      = 16;
    localparam int WIN_W       = 65;
    localparam int P_PROD_W    = 65;
    localparam int D_PROD_W    = 66;
    localparam int I_PROD_W    = 64;
    localparam int ACC_W       = 52;
    localparam int CFG_INDEX_W = 8;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic        [BAND_W-1:0] band_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // one in Q16.16 at the width of the window factors
    localparam logic signed [ERR_W-1:0] ONE_Q16 = 33'sd65536;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P          = 8'd0,
        REG_GAIN_I          = 8'd1,
        REG_GAIN_D          = 8'd2,
        REG_SEPARATION_BAND = 8'd3,
        REG_INTEGRAL_UPPER  = 8'd4,
        REG_INTEGRAL_LOWER  = 8'd5,
        REG_DRIVE_UPPER     = 8'd6,
        REG_DRIVE_LOWER     = 8'd7
    } cfg_reg_t;

    // reset values of the registers
    localparam q16_t  RST_GAIN_P         = 32'sd117965;
    localparam q16_t  RST_GAIN_I         = 32'sd6554;
    localparam q16_t  RST_GAIN_D         = 32'sd0;
    localparam band_t RST_BAND           = 31'd9830;
    localparam q16_t  RST_INTEGRAL_UPPER = 32'sd1572864;
    localparam q16_t  RST_INTEGRAL_LOWER = -32'sd1572864;
    localparam q16_t  RST_DRIVE_UPPER    = 32'sd2359296;
    localparam q16_t  RST_DRIVE_LOWER    = -32'sd2359296;

    typedef struct packed {
        q16_t  gain_p;
        q16_t  gain_i;
        q16_t  gain_d;
        band_t separation_band;
        q16_t  integral_upper;
        q16_t  integral_lower;
        q16_t  drive_upper;
        q16_t  drive_lower;
    } cfg_t;

    // one classified item between front and back
    typedef struct packed {
        err_t  err;
        diff_t diff;
        q16_t  integral;
        logic  in_window;
    } work_t;

    // upper limit tested first, then the lower one
    function automatic q16_t clamp_q16(input acc_t v, input q16_t lo, input q16_t hi);
        acc_t hi_w;
        acc_t lo_w;
        q16_t r;
        hi_w = $signed({{(ACC_W-DATA_W){hi[DATA_W-1]}}, hi});
        lo_w = $signed({{(ACC_W-DATA_W){lo[DATA_W-1]}}, lo});
        if (v > hi_w)
        begin
            r = hi;
        end
        else if (v < lo_w)
        begin
            r = lo;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/pid_is_ifs.sv -----
// sample channel: setpoint and measured value
interface pid_is_in_if;
    import pid_is_pkg::*;
    logic valid;
    logic ready;
    q16_t setpoint;
    q16_t measured;
    modport source (output valid, output setpoint, output measured, input ready);
    modport sink (input valid, input setpoint, input measured, output ready);
endinterface

// result channel: clamped drive
interface pid_is_out_if;
    import pid_is_pkg::*;
    logic valid;
    logic ready;
    q16_t drive;
    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

// register write channel
interface pid_is_cfg_if;
    import pid_is_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [DATA_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/pid_is_regs.sv -----
module pid_is_regs (
    input  logic              clk,
    input  logic              rst_n,
    pid_is_cfg_if.sink        cfg_wr,
    output pid_is_pkg::cfg_t  cfg
);
    import pid_is_pkg::*;

    cfg_t cfg_reg;

    // writes are always taken
    assign cfg_wr.ready = 1'b1;
    assign cfg = cfg_reg;

    // register file, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p          <= RST_GAIN_P;
            cfg_reg.gain_i          <= RST_GAIN_I;
            cfg_reg.gain_d          <= RST_GAIN_D;
            cfg_reg.separation_band <= RST_BAND;
            cfg_reg.integral_upper  <= RST_INTEGRAL_UPPER;
            cfg_reg.integral_lower  <= RST_INTEGRAL_LOWER;
            cfg_reg.drive_upper     <= RST_DRIVE_UPPER;
            cfg_reg.drive_lower     <= RST_DRIVE_LOWER;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                REG_GAIN_P:          cfg_reg.gain_p          <= cfg_wr.data;
                REG_GAIN_I:          cfg_reg.gain_i          <= cfg_wr.data;
                REG_GAIN_D:          cfg_reg.gain_d          <= cfg_wr.data;
                REG_SEPARATION_BAND: cfg_reg.separation_band <= cfg_wr.data[BAND_W-1:0];
                REG_INTEGRAL_UPPER:  cfg_reg.integral_upper  <= cfg_wr.data;
                REG_INTEGRAL_LOWER:  cfg_reg.integral_lower  <= cfg_wr.data;
                REG_DRIVE_UPPER:     cfg_reg.drive_upper     <= cfg_wr.data;
                REG_DRIVE_LOWER:     cfg_reg.drive_lower     <= cfg_wr.data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- hdl/pid_is_front.sv -----
`include "pid_integral_separation_macros.svh"

module pid_is_front (
    input  logic              clk,
    input  logic              rst_n,
    input  pid_is_pkg::cfg_t  cfg,
    pid_is_in_if.sink         sample,
    output pid_is_pkg::work_t push_data,
    output logic              push_valid,
    input  logic              push_ready
);
    import pid_is_pkg::*;

    logic                     accept;
    logic                     rdy1;
    logic                     rdy2;
    logic                     rdy3;

    q16_t                     integral_reg;
    q16_t                     integral_next;
    err_t                     prev_err_reg;
    err_t                     prev_err_next;
    err_t                     err_c;
    diff_t                    diff_c;
    logic signed [ISUM_W-1:0] isum_c;

    logic                     v1_reg;
    q16_t                     sp1_reg;
    q16_t                     ms1_reg;
    err_t                     err1_reg;
    diff_t                    diff1_reg;
    q16_t                     integ1_reg;

    err_t                     fac_hi_c;
    err_t                     fac_lo_c;
    logic signed [WIN_W-1:0]  win_hi_c;
    logic signed [WIN_W-1:0]  win_lo_c;

    logic                     v2_reg;
    q16_t                     ms2_reg;
    logic signed [WIN_W-1:0]  win_hi2_reg;
    logic signed [WIN_W-1:0]  win_lo2_reg;
    err_t                     err2_reg;
    diff_t                    diff2_reg;
    q16_t                     integ2_reg;

    logic signed [WIN_W-1:0]  ms_wide_c;
    logic                     in_win_c;

    logic                     v3_reg;
    work_t                    work3_reg;

    // stall chain toward the queue
    always_comb
    begin
        rdy3 = !v3_reg || push_ready;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
    end

    assign sample.ready = rdy1;
    assign accept       = sample.valid && rdy1;

    // error, difference and clamped integral of the item on the port
    always_comb
    begin
        err_c = $signed({sample.setpoint[DATA_W-1], sample.setpoint})
              - $signed({sample.measured[DATA_W-1], sample.measured});
        diff_c = $signed({err_c[ERR_W-1], err_c})
               - $signed({prev_err_reg[ERR_W-1], prev_err_reg});
        isum_c = $signed({{(ISUM_W-DATA_W){integral_reg[DATA_W-1]}}, integral_reg})
               + $signed({err_c[ERR_W-1], err_c});
        integral_next = clamp_q16(acc_t'(isum_c), cfg.integral_lower, cfg.integral_upper);
        prev_err_next = err_c;
    end

    // controller state, advanced once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else if (accept)
        begin
            integral_reg <= integral_next;
            prev_err_reg <= prev_err_next;
        end
    end

    // window factors and bounds
    always_comb
    begin
        fac_hi_c = ONE_Q16 + $signed({2'b00, cfg.separation_band});
        fac_lo_c = ONE_Q16 - $signed({2'b00, cfg.separation_band});
        win_hi_c = sp1_reg * fac_hi_c;
        win_lo_c = sp1_reg * fac_lo_c;
    end

    // measured value scaled to the bounds and compared
    always_comb
    begin
        ms_wide_c = $signed({{(WIN_W-DATA_W-FRAC_W){ms2_reg[DATA_W-1]}}, ms2_reg,
                             {FRAC_W{1'b0}}});
        in_win_c  = (ms_wide_c > win_lo2_reg) && (ms_wide_c < win_hi2_reg);
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= sample.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sp1_reg    <= sample.setpoint;
            ms1_reg    <= sample.measured;
            err1_reg   <= err_c;
            diff1_reg  <= diff_c;
            integ1_reg <= integral_next;
        end
        if (rdy2 && v1_reg)
        begin
            ms2_reg     <= ms1_reg;
            win_hi2_reg <= win_hi_c;
            win_lo2_reg <= win_lo_c;
            err2_reg    <= err1_reg;
            diff2_reg   <= diff1_reg;
            integ2_reg  <= integ1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            work3_reg.err       <= err2_reg;
            work3_reg.diff      <= diff2_reg;
            work3_reg.integral  <= integ2_reg;
            work3_reg.in_window <= in_win_c;
        end
    end

    assign push_valid = v3_reg;
    assign push_data  = work3_reg;

    // integral lands inside its limits after an update
    `PIS_ASSERT(a_integral_clamped, clk, rst_n,
        (accept && cfg.integral_lower <= cfg.integral_upper) |=> (integral_reg >= $past(cfg.integral_lower) && integral_reg <= $past(cfg.integral_upper)),
        "integral outside its limits")

endmodule

// ----- hdl/pid_is_queue.sv -----
`include "pid_integral_separation_macros.svh"

module pid_is_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pid_is_pkg::work_t push_data,
    input  logic              push_valid,
    output logic              push_ready,
    output pid_is_pkg::work_t pop_data,
    output logic              pop_valid,
    input  logic              pop_ready
);
    import pid_is_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // count may still be unknown before the first reset edge
    `PIS_ASSERT_ALWAYS(a_count_bound, clk, (!rst_n || (count_reg <= CNT_W'(DEPTH))),
        "queue count above depth")
    `PIS_ASSERT(a_count_up, clk, rst_n,
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1),
        "queue count missed a push")
    `PIS_ASSERT(a_count_down, clk, rst_n,
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1),
        "queue count missed a pop")

endmodule

// ----- hdl/pid_is_back.sv -----
`include "pid_integral_separation_macros.svh"

module pid_is_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pid_is_pkg::cfg_t  cfg,
    input  pid_is_pkg::work_t pop_data,
    input  logic              pop_valid,
    output logic              pop_ready,
    pid_is_out_if.source      result
);
    import pid_is_pkg::*;

    logic                       rdy1;
    logic                       rdy2;
    logic                       rdy3;
    logic                       take;

    logic                       v1_reg;
    logic signed [P_PROD_W-1:0] p1_reg;
    logic signed [D_PROD_W-1:0] d1_reg;
    logic signed [I_PROD_W-1:0] i1_reg;
    logic                       win1_reg;

    acc_t                       p_term_c;
    acc_t                       d_term_c;
    acc_t                       i_term_c;
    acc_t                       sum_c;

    logic                       v2_reg;
    acc_t                       sum2_reg;

    logic                       v3_reg;
    q16_t                       drive_reg;

    // stall chain from the result port
    always_comb
    begin
        rdy3 = !v3_reg || result.ready;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
    end

    assign pop_ready = rdy1;
    assign take      = pop_valid && rdy1;

    // terms rounded toward minus infinity, integral only inside the window
    always_comb
    begin
        p_term_c = acc_t'($signed(p1_reg[P_PROD_W-1:FRAC_W]));
        d_term_c = acc_t'($signed(d1_reg[D_PROD_W-1:FRAC_W]));
        i_term_c = win1_reg ? acc_t'($signed(i1_reg[I_PROD_W-1:FRAC_W])) : '0;
        sum_c    = p_term_c + d_term_c + i_term_c;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= pop_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // gain products, sum, output clamp
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p1_reg   <= cfg.gain_p * pop_data.err;
            d1_reg   <= cfg.gain_d * pop_data.diff;
            i1_reg   <= cfg.gain_i * pop_data.integral;
            win1_reg <= pop_data.in_window;
        end
        if (rdy2 && v1_reg)
        begin
            sum2_reg <= sum_c;
        end
        if (rdy3 && v2_reg)
        begin
            drive_reg <= clamp_q16(sum2_reg, cfg.drive_lower, cfg.drive_upper);
        end
    end

    assign result.valid = v3_reg;
    assign result.drive = drive_reg;

    // a waiting drive honors ordered limits
    `PIS_ASSERT(a_drive_clamped, clk, rst_n,
        (result.valid && cfg.drive_lower <= cfg.drive_upper) |-> (result.drive >= cfg.drive_lower && result.drive <= cfg.drive_upper),
        "drive outside its limits")

endmodule

// ----- hdl/pid_integral_separation.sv -----
// PID controller with integral separation, signed Q16.16. Each sample transfer carries a
// setpoint and a measured value and yields one clamped drive transfer, in order. The error is
// added to the integral, which is clamped to its limits; the integral term counts only while
// the measured value lies strictly inside setpoint*(1-band)..setpoint*(1+band), so a zero or
// negative setpoint never uses it. A new sample is taken every cycle unless a stall holds the
// input back: the integral and last error update at the input as each sample is taken, the
// window test runs in a three-stage front, a small queue follows, and three gain multipliers,
// a sum and the output clamp form a three-stage back. Registers are written over the cfg
// channel (index 0..7 in the order gain_p, gain_i, gain_d, separation_band, integral_upper,
// integral_lower, drive_upper, drive_lower; other indexes are ignored); the user must write
// them only while no sample is in flight, as the block itself does not enforce it. Reset
// restores the register defaults and clears the integral and last error at once.
module pid_integral_separation #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    pid_is_in_if.sink     sample,
    pid_is_out_if.source  result,
    pid_is_cfg_if.sink    cfg
);
    import pid_is_pkg::*;

    cfg_t  cfg_q;
    work_t push_data;
    logic  push_valid;
    logic  push_ready;
    work_t pop_data;
    logic  pop_valid;
    logic  pop_ready;

    // configuration registers
    pid_is_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg),
        .cfg    (cfg_q)
    );

    // error, integral and window classification
    pid_is_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_q),
        .sample     (sample),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // decoupling queue
    pid_is_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // gain products and output clamp
    pid_is_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_q),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

// ----- test/pid_integral_separation_tb.sv -----
module pid_integral_separation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pid_is_pkg::*;

    typedef logic signed [99:0] wide_t;

    // one directed sample, with a hand-computed drive where it is obvious
    typedef struct packed {
        q16_t setpoint;
        q16_t measured;
        logic pinned;
        q16_t drive;
    } probe_t;

    localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q_MIN = 32'sh8000_0000;
    localparam wide_t UNITY = 100'sd65536;

    // register indexes outside the map, written to check they are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW = 8'd8;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_TOP = 8'd255;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT        = 700;
    localparam int HOLD_CYCLES    = 120;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PROBE_COUNT    = 14;

    localparam cfg_t RESET_SETTINGS = '{RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_BAND,
                                        RST_INTEGRAL_UPPER, RST_INTEGRAL_LOWER,
                                        RST_DRIVE_UPPER, RST_DRIVE_LOWER};

    // lower limits above upper limits, derivative on, widest band
    localparam cfg_t INVERTED_SETTINGS = '{32'sd196608, 32'sd32768, -32'sd131072,
                                           31'h7FFF_FFFF, -32'sd327680, 32'sd327680,
                                           -32'sd655360, 32'sd655360};

    localparam cfg_t MIN_GAIN_SETTINGS = '{Q_MIN, Q_MIN, Q_MIN, 31'h7FFF_FFFF,
                                           Q_MAX, Q_MIN, Q_MAX, Q_MIN};

    localparam cfg_t MAX_GAIN_SETTINGS = '{Q_MAX, Q_MAX, Q_MAX, 31'd0,
                                           Q_MIN, Q_MAX, Q_MAX, Q_MIN};

    localparam q16_t CORNERS [5] = '{Q_MIN, -32'sd1, 32'sd0, 32'sd1, Q_MAX};

    // window edges at setpoint 10.0 with the reset band are 557060 and 753660
    localparam probe_t PROBES [PROBE_COUNT] = '{
        '{32'sd0, 32'sd0, 1'b1, 32'sd0},
        '{Q_MAX, Q_MIN, 1'b1, RST_DRIVE_UPPER},
        '{Q_MIN, Q_MAX, 1'b1, RST_DRIVE_LOWER},
        '{32'sd0, 32'sd0, 1'b1, 32'sd0},
        '{-32'sd655360, -32'sd655360, 1'b1, 32'sd0},
        '{32'sd655360, 32'sd655360, 1'b0, 32'sd0},
        '{32'sd655360, 32'sd557060, 1'b0, 32'sd0},
        '{32'sd655360, 32'sd557061, 1'b0, 32'sd0},
        '{32'sd655360, 32'sd753659, 1'b0, 32'sd0},
        '{32'sd655360, 32'sd753660, 1'b0, 32'sd0},
        '{Q_MAX, Q_MAX, 1'b0, 32'sd0},
        '{Q_MIN, Q_MIN, 1'b1, 32'sd0},
        '{32'sd1, 32'sd0, 1'b0, 32'sd0},
        '{-32'sd1, 32'sd0, 1'b0, 32'sd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    pid_is_in_if  sample_if ();
    pid_is_out_if result_if ();
    pid_is_cfg_if cfg_if ();

    pid_integral_separation u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // controller state as the testbench tracks it
    cfg_t model_cfg    = RESET_SETTINGS;
    q16_t integral_sum = '0;
    err_t err_hist     = '0;

    q16_t drive_expect [$];
    int   mismatch_count = 0;
    int   idle_cycles    = 0;
    bit   no_gaps        = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic wide_t clamp_wide(input wide_t v, input wide_t lo, input wide_t hi);
        // with crossed limits, values above the upper limit get it and all others the lower one
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    // exact product, floored to Q16.16
    function automatic wide_t q16_product(input wide_t a, input wide_t b);
        wide_t p;
        p = a * b;
        return p >>> FRAC_W;
    endfunction

    function automatic q16_t predict_drive(input q16_t sp, input q16_t ms);
        wide_t sp_w;
        wide_t ms_w;
        wide_t err_w;
        wide_t band_w;
        wide_t isum_w;
        wide_t diff_w;
        wide_t prev_w;
        wide_t drive_w;
        logic  in_window;
        sp_w   = sp;
        ms_w   = ms;
        band_w = model_cfg.separation_band;
        prev_w = err_hist;
        err_w  = sp_w - ms_w;

        // window test in Q32.32, empty for setpoint <= 0
        in_window = !(((ms_w <<< FRAC_W) <= sp_w * (UNITY - band_w)) ||
                      ((ms_w <<< FRAC_W) >= sp_w * (UNITY + band_w)));

        // integral always accumulates, then clamps
        isum_w = integral_sum;
        isum_w = clamp_wide(isum_w + err_w, $signed(model_cfg.integral_lower),
                            $signed(model_cfg.integral_upper));
        integral_sum = isum_w[DATA_W-1:0];

        diff_w  = err_w - prev_w;
        drive_w = q16_product($signed(model_cfg.gain_p), err_w) +
                  q16_product($signed(model_cfg.gain_d), diff_w);
        if (in_window)
        begin
            drive_w = drive_w + q16_product($signed(model_cfg.gain_i), isum_w);
        end
        drive_w = clamp_wide(drive_w, $signed(model_cfg.drive_lower),
                             $signed(model_cfg.drive_upper));

        err_hist = err_w[ERR_W-1:0];
        return drive_w[DATA_W-1:0];
    endfunction

    function automatic q16_t draw_gain();
        case ($urandom_range(0, 9))
            0:       return 32'sd0;
            1, 2:    return $urandom;
            default: return $signed($urandom_range(0, 32'd524288)) - 32'sd262144;
        endcase
    endfunction

    function automatic void draw_limits(output q16_t lo, output q16_t hi);
        q16_t a;
        q16_t b;
        a = $signed($urandom_range(0, 32'd262144000)) - 32'sd131072000;
        b = $signed($urandom_range(0, 32'd262144000)) - 32'sd131072000;
        case ($urandom_range(0, 19))
            0, 1:
            begin
                lo = Q_MIN;
                hi = Q_MAX;
            end
            2, 3, 4:
            begin
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            default:
            begin
                lo = (a > b) ? b : a;
                hi = (a > b) ? a : b;
            end
        endcase
    endfunction

    function automatic cfg_t draw_settings();
        cfg_t s;
        s.gain_p = draw_gain();
        s.gain_i = draw_gain();
        s.gain_d = draw_gain();
        case ($urandom_range(0, 9))
            0:       s.separation_band = '0;
            1, 2:    s.separation_band = BAND_W'($urandom_range(0, 32'h7FFF_FFFF));
            default: s.separation_band = BAND_W'($urandom_range(0, 32'd65536));
        endcase
        draw_limits(s.integral_lower, s.integral_upper);
        draw_limits(s.drive_lower, s.drive_upper);
        return s;
    endfunction

    function automatic void draw_sample(output q16_t sp, output q16_t ms);
        longint      sp_l;
        longint      ms_l;
        longint      half_l;
        longint      off_l;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // positive setpoint with measured around the window
            sp_l   = longint'($urandom_range(1, 32'h0400_0000));
            half_l = (sp_l * longint'(model_cfg.separation_band)) >>> FRAC_W;
            if (half_l > 64'sh2000_0000)
            begin
                half_l = 64'sh2000_0000;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                off_l = half_l - 1 + longint'($urandom_range(0, 2));
                ms_l  = ($urandom_range(0, 1) == 1) ? sp_l + off_l : sp_l - off_l;
            end
            else
            begin
                ms_l = sp_l - 2 * half_l - 2 + longint'($urandom_range(0, 32'(4 * half_l + 4)));
            end
            if ($urandom_range(0, 7) == 0)
            begin
                sp_l = -sp_l;
                ms_l = -ms_l;
            end
            if (ms_l > 64'sd2147483647)
            begin
                ms_l = 64'sd2147483647;
            end
            else if (ms_l < -64'sd2147483648)
            begin
                ms_l = -64'sd2147483648;
            end
            sp = sp_l[DATA_W-1:0];
            ms = ms_l[DATA_W-1:0];
        end
        else if (pick < 75)
        begin
            sp = $signed($urandom_range(0, 32'd13107200)) - 32'sd6553600;
            ms = $signed($urandom_range(0, 32'd13107200)) - 32'sd6553600;
        end
        else if (pick < 92)
        begin
            sp = $urandom;
            ms = $urandom;
        end
        else
        begin
            sp = CORNERS[$urandom_range(0, 4)];
            ms = CORNERS[$urandom_range(0, 4)];
        end
    endfunction

    // one sample transfer; the drive is predicted when it is taken
    task automatic send_sample(input q16_t sp, input q16_t ms, input bit pinned,
                               input q16_t pin_drive);
        int unsigned gap;
        q16_t        predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid    <= 1'b1;
        sample_if.setpoint <= sp;
        sample_if.measured <= ms;
        @(posedge clk);
        while (!sample_if.ready)
        begin
            @(posedge clk);
        end
        predicted = predict_drive(sp, ms);
        drive_expect.push_back(pinned ? pin_drive : predicted);
        @(negedge clk);
    endtask

    // one register transfer; valid is left high for the next one
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_GAIN_P:          model_cfg.gain_p = value;
            REG_GAIN_I:          model_cfg.gain_i = value;
            REG_GAIN_D:          model_cfg.gain_d = value;
            REG_SEPARATION_BAND: model_cfg.separation_band = value[BAND_W-1:0];
            REG_INTEGRAL_UPPER:  model_cfg.integral_upper = value;
            REG_INTEGRAL_LOWER:  model_cfg.integral_lower = value;
            REG_DRIVE_UPPER:     model_cfg.drive_upper = value;
            REG_DRIVE_LOWER:     model_cfg.drive_lower = value;
            default:             ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_settings(input cfg_t s, input logic band_msb,
                                    input logic [CFG_INDEX_W-1:0] spare_idx);
        write_reg(REG_GAIN_P, s.gain_p);
        write_reg(REG_GAIN_I, s.gain_i);
        write_reg(REG_GAIN_D, s.gain_d);
        write_reg(REG_SEPARATION_BAND, {band_msb, s.separation_band});
        write_reg(REG_INTEGRAL_UPPER, s.integral_upper);
        write_reg(REG_INTEGRAL_LOWER, s.integral_lower);
        write_reg(REG_DRIVE_UPPER, s.drive_upper);
        write_reg(REG_DRIVE_LOWER, s.drive_lower);
        write_reg(spare_idx, $urandom);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic walk_probes(input bit use_pins);
        for (int k = 0; k < PROBE_COUNT; k++)
        begin
            send_sample(PROBES[k].setpoint, PROBES[k].measured,
                        use_pins && PROBES[k].pinned, PROBES[k].drive);
        end
        sample_if.valid <= 1'b0;
    endtask

    // every drive back before registers change
    task automatic wait_drained();
        while (drive_expect.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // drive receiver with random stalls and one long hold-off
    initial
    begin : drive_sink
        int unsigned stall;
        int          taken;
        result_if.ready = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken == HOLD_AT)
            begin
                stall = HOLD_CYCLES;
            end
            else
            begin
                stall = no_gaps ? 0 : $urandom_range(0, 3);
            end
            if (stall != 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid)
            begin
                @(posedge clk);
            end
            taken++;
            @(negedge clk);
        end
    end

    // compare each drive transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (drive_expect.size() == 0)
            begin
                report_mismatch($sformatf("unexpected drive transfer %0d", result_if.drive));
            end
            else if (result_if.drive !== drive_expect[0])
            begin
                report_mismatch($sformatf("drive %0d, expected %0d", result_if.drive,
                                          drive_expect[0]));
                void'(drive_expect.pop_front());
            end
            else
            begin
                void'(drive_expect.pop_front());
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
                 (cfg_if.valid && cfg_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        cfg_t                   settings;
        q16_t                   sp;
        q16_t                   ms;
        logic                   band_msb;
        logic [CFG_INDEX_W-1:0] spare_idx;
        rst_n              = 1'b0;
        sample_if.valid    = 1'b0;
        sample_if.setpoint = '0;
        sample_if.measured = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed samples at reset settings, then with crossed limits
        walk_probes(1'b1);
        wait_drained();
        program_settings(INVERTED_SETTINGS, 1'b1, REG_SPARE_LOW);
        walk_probes(1'b0);

        // random phases, each under its own register settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            band_msb  = 1'($urandom_range(0, 1));
            spare_idx = CFG_INDEX_W'($urandom_range(REG_SPARE_LOW, REG_SPARE_TOP));
            if (phase == 0)
            begin
                settings  = MIN_GAIN_SETTINGS;
                band_msb  = 1'b1;
                spare_idx = REG_SPARE_TOP;
            end
            else if (phase == 1)
            begin
                settings = MAX_GAIN_SETTINGS;
                band_msb = 1'b0;
            end
            else if (phase == PHASES - 1)
            begin
                settings = RESET_SETTINGS;
            end
            else
            begin
                settings = draw_settings();
            end
            program_settings(settings, band_msb, spare_idx);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                begin
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                draw_sample(sp, ms);
                send_sample(sp, ms, 1'b0, '0);
            end
            sample_if.valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && drive_expect.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pid_is_pkg.sv
hdl/pid_is_ifs.sv
hdl/pid_is_regs.sv
hdl/pid_is_front.sv
hdl/pid_is_queue.sv
hdl/pid_is_back.sv
hdl/pid_integral_separation.sv
test/pid_integral_separation_tb.sv
